>>> design/dfr_pkg.sv
// shared types, constants and the crc-16 byte step for the frame deframer
// no dependencies; used by the top, dfr_ctrl and dfr_datapath of the block

package dfr_pkg;

  localparam int unsigned SOLUTION_BYTES_DEF = 76;
  localparam logic [7:0]  START_A            = 8'h5A;
  localparam logic [7:0]  START_B            = 8'hA5;
  localparam logic [7:0]  TAG_RESET          = 8'h91;
  localparam logic [15:0] CRC_POLY           = 16'h1021;
  localparam int unsigned WORD_INDEX_W       = 5;
  localparam int unsigned OUT_DATA_W         = 40;

  typedef enum logic [3:0] {
    ST_HUNT1,
    ST_HUNT2,
    ST_LEN_LO,
    ST_LEN_HI,
    ST_CRC_LO,
    ST_CRC_HI,
    ST_DATA,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } dfr_state_t;

  typedef struct packed {
    logic seed;
    logic len_lo;
    logic len_hi;
    logic crc_lo;
    logic crc_hi;
    logic data;
    logic end_frame;
    logic emit_clr;
    logic emit_load;
    logic emit_next;
  } dfr_cmd_t;

  typedef struct packed {
    logic is_start_a;
    logic is_start_b;
    logic len_zero;
    logic data_end;
    logic frame_ok;
    logic last_word;
    logic out_taken;
  } dfr_sts_t;

  // msb-first crc-16 over one byte, no final xor
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  localparam logic [15:0] CRC_SEED = crc_byte(crc_byte(16'h0000, START_A), START_B);

endpackage

>>> design/imu_frame_deframer_crc16.sv
// top level of the checked serial frame deframer
// depends on dfr_pkg, dfr_ctrl, dfr_datapath (and dfr_ram through the datapath)
//
// in_*: one received serial byte per item. frame = 0x5A 0xA5, length (le16),
//   crc (le16), payload. crc-16 poly 0x1021, init 0, msb first, over start,
//   length and payload bytes.
// out_*: one 32-bit little-endian solution word per item, tlast on the final word.
//   only frames with a matching crc, a length of at least SOLUTION_BYTES and the
//   tag as first payload byte produce words; all others are dropped silently.
// cfg_*: solution_tag write, always ready; user rule, not enforced: taken while block idle.
// throughput: while parsing, one byte per cycle (in_tready high).
// after the last payload byte of an accepted frame the input is held off while
//   the store is read out: each word takes a ram read, an output load and a
//   handshake, and the next word's ram read starts only after that handshake;
//   a burst holds ceil(SOLUTION_BYTES/4) words, the last one with tlast.
// a stalled receiver holds the output register and the emit sequence waits.
// reset (rst_n low, synchronous) returns to the start-byte hunt and restores
//   the tag to 0x91; the solution store needs no clearing.

module imu_frame_deframer_crc16 #(
  parameter int SOLUTION_BYTES = dfr_pkg::SOLUTION_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] rx_byte
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [dfr_pkg::OUT_DATA_W-1:0] out_tdata,  // [4:0] word_index, [36:5] payload_word
  output logic                           out_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [7:0]                     cfg_data
);

  dfr_pkg::dfr_cmd_t cmd;
  dfr_pkg::dfr_sts_t sts;

  assign cfg_ready = 1'b1;

  dfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dfr_datapath #(
    .SOLUTION_BYTES(SOLUTION_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .rx_byte   (in_tdata),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_tready(out_tready),
    .out_tvalid(out_tvalid),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // emit and parse never overlap
  a_emit_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while a word is pending");

  // a taken final word ends the burst
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (!out_tvalid && in_tready))
    else $error("burst continues after last word");

  // a taken word is followed by a store read cycle, or by the hunt after the last word
  a_word_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready) |=> !out_tvalid)
    else $error("word valid straight after handshake");

  // an accepted byte never yields a word in the next cycle
  a_byte_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !out_tvalid)
    else $error("word valid straight after a byte");

endmodule

>>> design/dfr_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies

module dfr_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 19,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/dfr_ctrl.sv
// controller state machine for the frame deframer: parse phases and word emit
// depends on dfr_pkg for the state, command and status types

module dfr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  dfr_pkg::dfr_sts_t sts,
  output dfr_pkg::dfr_cmd_t cmd
);

  dfr_pkg::dfr_state_t state_r, state_nxt;
  logic acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dfr_pkg::ST_HUNT1;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    acc       = 1'b0;
    case (state_r)
      dfr_pkg::ST_HUNT1: begin
        in_tready = 1'b1;
        acc       = in_tvalid;
        if (acc) begin
          state_nxt = sts.is_start_a ? dfr_pkg::ST_HUNT2 : dfr_pkg::ST_HUNT1;
        end
      end
      dfr_pkg::ST_HUNT2: begin
        in_tready = 1'b1;
        acc       = in_tvalid;
        if (acc) begin
          if (sts.is_start_b) begin
            cmd.seed  = 1'b1;
            state_nxt = dfr_pkg::ST_LEN_LO;
          end else begin
            state_nxt = dfr_pkg::ST_HUNT1;
          end
        end
      end
      dfr_pkg::ST_LEN_LO: begin
        in_tready = 1'b1;
        acc       = in_tvalid;
        if (acc) begin
          cmd.len_lo = 1'b1;
          state_nxt  = dfr_pkg::ST_LEN_HI;
        end
      end
      dfr_pkg::ST_LEN_HI: begin
        in_tready = 1'b1;
        acc       = in_tvalid;
        if (acc) begin
          cmd.len_hi = 1'b1;
          state_nxt  = dfr_pkg::ST_CRC_LO;
        end
      end
      dfr_pkg::ST_CRC_LO: begin
        in_tready = 1'b1;
        acc       = in_tvalid;
        if (acc) begin
          cmd.crc_lo = 1'b1;
          state_nxt  = dfr_pkg::ST_CRC_HI;
        end
      end
      dfr_pkg::ST_CRC_HI: begin
        in_tready = 1'b1;
        acc       = in_tvalid;
        if (acc) begin
          cmd.crc_hi = 1'b1;
          if (sts.len_zero) begin
            cmd.end_frame = 1'b1;
            state_nxt     = dfr_pkg::ST_HUNT1;
          end else begin
            state_nxt = dfr_pkg::ST_DATA;
          end
        end
      end
      dfr_pkg::ST_DATA: begin
        in_tready = 1'b1;
        acc       = in_tvalid;
        if (acc) begin
          cmd.data = 1'b1;
          if (sts.data_end) begin
            cmd.end_frame = 1'b1;
            if (sts.frame_ok) begin
              cmd.emit_clr = 1'b1;
              state_nxt    = dfr_pkg::ST_EMIT_RD;
            end else begin
              state_nxt = dfr_pkg::ST_HUNT1;
            end
          end
        end
      end
      dfr_pkg::ST_EMIT_RD: begin
        state_nxt = dfr_pkg::ST_EMIT_LD;
      end
      dfr_pkg::ST_EMIT_LD: begin
        cmd.emit_load = 1'b1;
        state_nxt     = dfr_pkg::ST_EMIT_WAIT;
      end
      dfr_pkg::ST_EMIT_WAIT: begin
        if (sts.out_taken) begin
          if (sts.last_word) begin
            state_nxt = dfr_pkg::ST_HUNT1;
          end else begin
            cmd.emit_next = 1'b1;
            state_nxt     = dfr_pkg::ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = dfr_pkg::ST_HUNT1;
      end
    endcase
  end

endmodule

>>> design/dfr_datapath.sv
// datapath of the frame deframer: length, crc, byte packing, solution store, output register
// depends on dfr_pkg and dfr_ram

module dfr_datapath #(
  parameter int SOLUTION_BYTES = dfr_pkg::SOLUTION_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [7:0]                          rx_byte,
  input  logic                                cfg_valid,
  input  logic [7:0]                          cfg_data,
  input  dfr_pkg::dfr_cmd_t                   cmd,
  output dfr_pkg::dfr_sts_t                   sts,
  input  logic                                out_tready,
  output logic                                out_tvalid,
  output logic [dfr_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tlast
);

  localparam int WORD_COUNT = (SOLUTION_BYTES + 3) / 4;
  localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam logic [15:0] SB16   = 16'(SOLUTION_BYTES);
  localparam logic [15:0] SB_END = 16'(SOLUTION_BYTES - 1);
  localparam logic [AW-1:0] LAST_W = AW'(WORD_COUNT - 1);

  logic [7:0]  tag_r;
  logic [15:0] frame_length_r, frame_length_nxt;
  logic [7:0]  crc_low_r;
  logic [15:0] received_crc_r;
  logic [15:0] running_crc_r, running_crc_nxt;
  logic [15:0] bytes_received_r;
  logic [15:0] count_inc;
  logic [7:0]  first_byte_r;
  logic [7:0]  first_byte_eff;
  logic [31:0] acc_r, acc_nxt;
  logic [15:0] crc_step;
  logic        store_en;
  logic        ram_we;
  logic [AW-1:0] word_cnt_r;
  logic [31:0] ram_rdata;
  logic        out_valid_r;
  logic [31:0] out_word_r;
  logic [4:0]  out_idx_r;
  logic        out_last_r;
  logic [AW+4:0] idx_wide;

  assign crc_step  = dfr_pkg::crc_byte(running_crc_r, rx_byte);
  assign count_inc = bytes_received_r + 16'd1;
  assign store_en  = bytes_received_r < SB16;
  assign ram_we    = cmd.data && store_en
                     && (bytes_received_r[1:0] == 2'd3 || bytes_received_r == SB_END);
  assign first_byte_eff = (bytes_received_r == 16'd0) ? rx_byte : first_byte_r;

  always_comb begin
    case (bytes_received_r[1:0])
      2'd0:    acc_nxt = {24'h000000, rx_byte};
      2'd1:    acc_nxt = {16'h0000, rx_byte, acc_r[7:0]};
      2'd2:    acc_nxt = {8'h00, rx_byte, acc_r[15:0]};
      default: acc_nxt = {rx_byte, acc_r[23:0]};
    endcase
  end

  always_comb begin
    frame_length_nxt = frame_length_r;
    if (cmd.len_lo) begin
      frame_length_nxt = {8'h00, rx_byte};
    end else if (cmd.len_hi) begin
      frame_length_nxt = {rx_byte, frame_length_r[7:0]};
    end else if (cmd.end_frame) begin
      frame_length_nxt = 16'h0000;
    end
    running_crc_nxt = running_crc_r;
    if (cmd.seed) begin
      running_crc_nxt = dfr_pkg::CRC_SEED;
    end else if (cmd.len_lo || cmd.len_hi || cmd.data) begin
      running_crc_nxt = crc_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r            <= dfr_pkg::TAG_RESET;
      frame_length_r   <= 16'h0000;
      crc_low_r        <= 8'h00;
      received_crc_r   <= 16'h0000;
      running_crc_r    <= 16'h0000;
      bytes_received_r <= 16'h0000;
      out_valid_r      <= 1'b0;
      word_cnt_r       <= '0;
    end else begin
      if (cfg_valid) begin
        tag_r <= cfg_data;
      end
      frame_length_r <= frame_length_nxt;
      running_crc_r  <= running_crc_nxt;
      if (cmd.crc_lo) begin
        crc_low_r <= rx_byte;
      end
      if (cmd.crc_hi) begin
        received_crc_r <= {rx_byte, crc_low_r};
      end
      if (cmd.len_hi) begin
        bytes_received_r <= 16'h0000;
      end else if (cmd.data) begin
        bytes_received_r <= count_inc;
      end
      if (cmd.emit_clr) begin
        word_cnt_r <= '0;
      end else if (cmd.emit_next) begin
        word_cnt_r <= word_cnt_r + AW'(1);
      end
      if (cmd.emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign idx_wide = {5'b00000, word_cnt_r};

  always_ff @(posedge clk) begin
    if (cmd.data && store_en) begin
      acc_r <= acc_nxt;
    end
    if (cmd.data && bytes_received_r == 16'd0) begin
      first_byte_r <= rx_byte;
    end
    if (cmd.emit_load) begin
      out_word_r <= ram_rdata;
      out_idx_r  <= idx_wide[4:0];
      out_last_r <= (word_cnt_r == LAST_W);
    end
  end

  dfr_ram #(
    .WIDTH (32),
    .DEPTH (WORD_COUNT),
    .ADDR_W(AW)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(bytes_received_r[AW+1:2]),
    .wdata(acc_nxt),
    .raddr(word_cnt_r),
    .rdata(ram_rdata)
  );

  assign sts.is_start_a = (rx_byte == dfr_pkg::START_A);
  assign sts.is_start_b = (rx_byte == dfr_pkg::START_B);
  assign sts.len_zero   = (frame_length_r == 16'h0000);
  assign sts.data_end   = (count_inc == frame_length_r);
  assign sts.frame_ok   = (crc_step == received_crc_r) && (frame_length_r >= SB16)
                          && (first_byte_eff == tag_r);
  assign sts.last_word  = (word_cnt_r == LAST_W);
  assign sts.out_taken  = out_valid_r && out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_word_r, out_idx_r};
  assign out_tlast  = out_last_r;

endmodule

>>> tb/deframer_checker.sv
// result checker for the crc-16 frame deframer: follows the byte stream and the tag writes,
// works out the solution words each frame should give and compares every word taken
// depends on dfr_pkg; deframer_tb_pkg below is shared with the testbench top

package deframer_tb_pkg;

  localparam int unsigned SOL_BYTES = dfr_pkg::SOLUTION_BYTES_DEF;
  localparam int unsigned SOL_WORDS = (SOL_BYTES + 3) / 4;

  typedef struct packed {
    logic [4:0]  index;
    logic [31:0] word;
    logic        last;
  } solution_word_t;

  // bit-serial crc-16, poly 0x1021, msb first
  function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] data);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ data[i];
      r = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ dfr_pkg::CRC_POLY;
      end
    end
    return r;
  endfunction

endpackage

module deframer_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic        out_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  output int          fail_count,
  output int          words_outstanding
);

  import dfr_pkg::*;
  import deframer_tb_pkg::*;

  localparam int MAX_REPORTS = 100;

  dfr_state_t     phase;
  logic [15:0]    frame_len;
  logic [15:0]    sent_crc;
  logic [15:0]    calc_crc;
  logic [15:0]    payload_seen;
  logic [7:0]     crc_lo_byte;
  logic [7:0]     tag;
  logic [31:0]    kept[SOL_WORDS];
  solution_word_t words_due[$];

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("mismatch on %s at %0t: got 0x%0h, expected 0x%0h", what, $time, got, want);
    end
  endtask

  task automatic clear_parser();
    phase = ST_HUNT1;
    frame_len = '0;
    sent_crc = '0;
    calc_crc = '0;
    payload_seen = '0;
    crc_lo_byte = '0;
    tag = TAG_RESET;
    for (int i = 0; i < SOL_WORDS; i++) begin
      kept[i] = '0;
    end
    words_due.delete();
  endtask

  task automatic close_frame();
    solution_word_t w;
    if (calc_crc == sent_crc && frame_len >= 16'(SOL_BYTES) && kept[0][7:0] == tag) begin
      for (int n = 0; n < SOL_WORDS; n++) begin
        w.index = 5'(n);
        w.word = kept[n];
        w.last = (n == SOL_WORDS - 1);
        words_due = {words_due, w};
      end
    end
    phase = ST_HUNT1;
    frame_len = '0;
  endtask

  task automatic take_rx_byte(input logic [7:0] b);
    int unsigned w;
    int unsigned lane;
    case (phase)
      ST_HUNT2: begin
        if (b == START_B) begin
          calc_crc = crc16_step(crc16_step(16'h0000, START_A), START_B);
          phase = ST_LEN_LO;
        end else begin
          phase = ST_HUNT1;
        end
      end
      ST_LEN_LO: begin
        frame_len = {8'h00, b};
        calc_crc = crc16_step(calc_crc, b);
        phase = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        frame_len[15:8] = b;
        calc_crc = crc16_step(calc_crc, b);
        payload_seen = '0;
        phase = ST_CRC_LO;
      end
      ST_CRC_LO: begin
        crc_lo_byte = b;
        phase = ST_CRC_HI;
      end
      ST_CRC_HI: begin
        sent_crc = {b, crc_lo_byte};
        if (frame_len == 16'h0000) begin
          close_frame();
        end else begin
          phase = ST_DATA;
        end
      end
      ST_DATA: begin
        calc_crc = crc16_step(calc_crc, b);
        if (payload_seen < 16'(SOL_BYTES)) begin
          w = 32'(payload_seen) >> 2;
          lane = 32'(payload_seen[1:0]);
          if (lane == 0) begin
            kept[w] = '0;
          end
          kept[w][lane*8 +: 8] = b;
        end
        payload_seen = payload_seen + 16'd1;
        if (payload_seen == frame_len) begin
          close_frame();
        end
      end
      default: begin
        phase = (b == START_A) ? ST_HUNT2 : ST_HUNT1;
      end
    endcase
  endtask

  task automatic check_word();
    solution_word_t want;
    if (words_due.size() == 0) begin
      note_mismatch("word with none due", out_tdata[36:5], '0);
      return;
    end
    want = words_due.pop_front();
    if (out_tdata[4:0] !== want.index) begin
      note_mismatch("word_index", 32'(out_tdata[4:0]), 32'(want.index));
    end
    if (out_tdata[36:5] !== want.word) begin
      note_mismatch("payload_word", out_tdata[36:5], want.word);
    end
    if (out_tlast !== want.last) begin
      note_mismatch("last_word", 32'(out_tlast), 32'(want.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
    end else begin
      if (out_tvalid && out_tready) begin
        check_word();
      end
      if (in_tvalid && in_tready) begin
        take_rx_byte(in_tdata);
      end
      if (cfg_valid && cfg_ready) begin
        tag = cfg_data;
      end
    end
    words_outstanding = words_due.size();
  end

endmodule

>>> tb/imu_frame_deframer_crc16_test.sv
// testbench top for imu_frame_deframer_crc16: drives serial bytes, tag writes and output
// back-pressure, and gives the verdict from the failure count of deframer_checker
// depends on dfr_pkg, deframer_tb_pkg and deframer_checker

module imu_frame_deframer_crc16_test;

  import dfr_pkg::*;
  import deframer_tb_pkg::*;

  localparam int          MAX_GAP       = 12;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          TAIL_CYCLES   = 60;
  localparam int          PHASE_BYTES   = 80;
  localparam int          FILL_RANDOM   = -1;
  localparam int unsigned CYCLE_LIMIT   = 1000000;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data   = 8'h00;

  int          fail_count;
  int          words_outstanding;
  int unsigned bytes_sent   = 0;
  int unsigned cycles       = 0;
  bit          send_brisk   = 1'b0;
  bit          recv_brisk   = 1'b0;
  bit          hold_request = 1'b0;

  imu_frame_deframer_crc16 u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  deframer_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_tvalid         (in_tvalid),
    .in_tready         (in_tready),
    .in_tdata          (in_tdata),
    .out_tvalid        (out_tvalid),
    .out_tready        (out_tready),
    .out_tdata         (out_tdata),
    .out_tlast         (out_tlast),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .words_outstanding (words_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // output side: random stalls, brisk stretches and one long hold-off on request
  initial begin
    int unsigned stall;
    forever begin
      if ($urandom_range(0, 15) == 0) begin
        recv_brisk = !recv_brisk;
      end
      if (hold_request) begin
        stall = HOLD_CYCLES;
        hold_request = 1'b0;
      end else begin
        stall = recv_brisk ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  task automatic put_byte(input logic [7:0] b);
    int unsigned gap;
    gap = send_brisk ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [15:0] len, input logic [7:0] first,
                            input int fill, input bit bad_crc);
    logic [7:0]  body[$];
    logic [15:0] sum;
    for (int unsigned i = 0; i < 32'(len); i++) begin
      if (i == 0) begin
        body = {body, first};
      end else if (fill < 0) begin
        body = {body, 8'($urandom_range(0, 255))};
      end else begin
        body = {body, 8'(fill)};
      end
    end
    sum = crc16_step(crc16_step(16'h0000, START_A), START_B);
    sum = crc16_step(crc16_step(sum, len[7:0]), len[15:8]);
    foreach (body[i]) begin
      sum = crc16_step(sum, body[i]);
    end
    if (bad_crc) begin
      sum = sum ^ (16'h0001 << $urandom_range(0, 15));
    end
    put_byte(START_A);
    put_byte(START_B);
    put_byte(len[7:0]);
    put_byte(len[15:8]);
    put_byte(sum[7:0]);
    put_byte(sum[15:8]);
    foreach (body[i]) begin
      put_byte(body[i]);
    end
  endtask

  // line noise that never forms a start pair and never leaves a half-seen one
  task automatic send_noise(input int unsigned n);
    logic [7:0] b;
    logic [7:0] prev;
    prev = 8'h00;
    for (int unsigned i = 0; i < n; i++) begin
      b = ($urandom_range(0, 3) == 0) ? START_A : 8'($urandom_range(0, 255));
      if ((prev == START_A && b == START_B) || (i == n - 1 && b == START_A)) begin
        b = 8'h00;
      end
      put_byte(b);
      prev = b;
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (words_outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tag(input logic [7:0] t);
    cfg_valid <= 1'b1;
    cfg_data <= t;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
  endtask

  task automatic run_traffic(input logic [7:0] tag);
    int unsigned start_bytes;
    int unsigned pick;
    int unsigned good_frames;
    logic [15:0] len;
    start_bytes = bytes_sent;
    good_frames = 0;
    while (bytes_sent - start_bytes < PHASE_BYTES || good_frames == 0) begin
      send_brisk = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 7) == 0) begin
        len = 16'($urandom_range(SOL_BYTES + 1, 2 * SOL_BYTES));
      end else begin
        len = 16'($urandom_range(SOL_BYTES, SOL_BYTES + 12));
      end
      if (pick < 55) begin
        send_frame(len, tag, FILL_RANDOM, 1'b0);
        good_frames++;
      end else if (pick < 65) begin
        send_frame(len, tag, FILL_RANDOM, 1'b1);
      end else if (pick < 75) begin
        send_frame(len, tag ^ 8'($urandom_range(1, 255)), FILL_RANDOM, 1'b0);
      end else if (pick < 82) begin
        send_frame(16'($urandom_range(1, SOL_BYTES - 1)), tag, FILL_RANDOM, 1'b0);
      end else if (pick < 87) begin
        send_frame(16'h0000, tag, FILL_RANDOM, 1'b0);
      end else begin
        send_noise($urandom_range(1, 8));
      end
    end
    send_brisk = 1'b0;
  endtask

  initial begin
    logic [7:0] tags[2];
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // a bad second start byte is not taken as a new first one
    put_byte(START_A);
    put_byte(START_A);
    put_byte(START_B);
    put_byte(8'h00);
    send_frame(16'(SOL_BYTES + 8), TAG_RESET, 8'hFF, 1'b0);
    send_frame(16'h0000, TAG_RESET, FILL_RANDOM, 1'b0);
    send_frame(16'(SOL_BYTES - 1), TAG_RESET, FILL_RANDOM, 1'b0);
    send_frame(16'(SOL_BYTES), TAG_RESET ^ 8'h01, FILL_RANDOM, 1'b0);
    send_frame(16'(SOL_BYTES), TAG_RESET, FILL_RANDOM, 1'b1);

    tags[0] = 8'hFF;
    tags[1] = 8'h00;
    foreach (tags[i]) begin
      drain();
      write_tag(tags[i]);
      if (i == 0) begin
        hold_request = 1'b1;
      end
      run_traffic(tags[i]);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
